>>> hw/rtl/trk_pkg.sv
// Shared types, constants and the arctangent table of the range/bearing tracker.
// Used by trk_ctrl, trk_dp and position_to_range_bearing_tracker; no dependencies.

package trk_pkg;

	localparam int ANGLE_BITS   = 16;
	localparam int ANGLE_SHIFT  = 32 - ANGLE_BITS;
	localparam int CORDIC_STEPS = 16;
	localparam int CW           = 44;

	localparam logic [5:0] MUL_LAST   = 6'd6;
	localparam logic [5:0] DIV_LAST   = 6'd52;
	localparam logic [5:0] SQRT_STEPS = 6'd32;
	localparam logic [5:0] ROT_LAST   = 6'(CORDIC_STEPS - 1);

	localparam logic [63:0] DT_MIN    = 64'd1000;
	localparam logic [63:0] DT_MAX    = 64'd1000000;
	localparam logic signed [32:0] US_PER_S = 33'sd1000000;

	localparam logic [1:0] CFG_ENABLE = 2'd0;
	localparam logic [1:0] CFG_TARGET = 2'd1;

	localparam int IN_W  = 160;
	localparam int OUT_W = 344;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MUL  = 7'b0000010,
		ST_DIV  = 7'b0000100,
		ST_INIT = 7'b0001000,
		ST_NORM = 7'b0010000,
		ST_ROT  = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

	typedef struct packed {
		logic       load;
		logic       mul;
		logic       div;
		logic       init;
		logic       norm;
		logic       rot;
		logic       emit;
		logic [5:0] idx;
	} cmd_t;

	typedef struct packed {
		logic enabled;
		logic norm_done;
		logic out_busy;
	} sts_t;

	// atan(2^-i) in units of pi/2^31 radian
	function automatic logic [31:0] atan_lut(input logic [4:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

	// shift that brings the larger magnitude towards [2^40, 2^41)
	function automatic logic [3:0] norm_shift(input logic [CW-1:0] m);
		logic [3:0] s;
		priority if (m < (44'd1 << 32)) s = 4'd8;
		else if (m < (44'd1 << 36)) s = 4'd4;
		else if (m < (44'd1 << 38)) s = 4'd2;
		else if (m < (44'd1 << 40)) s = 4'd1;
		else s = 4'd0;
		return s;
	endfunction

	function automatic logic [CW-1:0] mag_max(input logic signed [CW-1:0] x,
			input logic signed [CW-1:0] y);
		logic [CW-1:0] ay;
		ay = y[CW-1] ? CW'(-y) : CW'(y);
		return (CW'(x) > ay) ? CW'(x) : ay;
	endfunction

endpackage

>>> hw/rtl/trk_ctrl.sv
// Sequencer of the tracker: steps the datapath through multiply, divide/root,
// angle setup, normalise, rotate and report. Depends on trk_pkg.

module trk_ctrl import trk_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t     state_q, state_d;
	logic [5:0] cnt_q, cnt_d;
	logic       accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		cmd.idx  = cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && sts.enabled) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL;
					cnt_d    = '0;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				cnt_d   = cnt_q + 6'd1;
				if (cnt_q == MUL_LAST) begin
					state_d = ST_DIV;
					cnt_d   = '0;
				end
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				cnt_d   = cnt_q + 6'd1;
				if (cnt_q == DIV_LAST) begin
					state_d = ST_INIT;
					cnt_d   = '0;
				end
			end
			ST_INIT: begin
				cmd.init = 1'b1;
				state_d  = ST_NORM;
			end
			ST_NORM: begin
				if (sts.norm_done) begin
					state_d = ST_ROT;
					cnt_d   = '0;
				end else begin
					cmd.norm = 1'b1;
				end
			end
			ST_ROT: begin
				cmd.rot = 1'b1;
				cnt_d   = cnt_q + 6'd1;
				if (cnt_q == ROT_LAST) begin
					state_d = ST_FIN;
					cnt_d   = '0;
				end
			end
			ST_FIN: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept && sts.enabled |=> state_q == ST_MUL)
		else $error("enabled transfer did not start work");
	a_rot_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROT && cnt_q == ROT_LAST |=> state_q == ST_FIN)
		else $error("rotation did not end at the last step");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !sts.out_busy)
		else $error("report emitted over a pending one");

endmodule

>>> hw/rtl/trk_dp.sv
// Datapath of the tracker: sample and history registers, shared multiplier,
// three dividers, two square roots, two CORDIC units and the report register.
// Depends on trk_pkg.

module trk_dp import trk_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [15:0]      cfg_data,
	input  logic [IN_W-1:0]  in_data,
	input  cmd_t             cmd,
	output sts_t             sts,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [OUT_W-1:0] out_data
);

	logic        enable_q;
	logic [15:0] target_q;

	logic [63:0]        t_q, prev_t_q;
	logic signed [31:0] p_q [3];
	logic signed [31:0] prev_q [3];
	logic signed [31:0] vel_q [3];

	logic        upd_q;
	logic [19:0] dt_q;
	logic [63:0] dt;

	logic signed [32:0] diff [3];
	logic signed [32:0] op_a, op_b;
	logic signed [65:0] prod_q;
	logic [65:0]        prod_mag;
	logic [1:0]         lane;

	logic [63:0] sq_q, nh_q, ns_q, rh_q, rs_q;
	logic [63:0] sqrt_bit, th, ts;

	logic        dneg_q [3];
	logic [52:0] quot_q [3];
	logic [19:0] rem_q [3];
	logic [20:0] sh [3];
	logic        ge [3];

	logic signed [CW-1:0] ax_q, ay_q, ex_q, ey_q;
	logic [31:0]          aacc_q, eacc_q;
	logic                 azero_q, ezero_q;
	logic [CW-1:0]        am, em;
	logic                 adone, edone;
	logic [4:0]           ri;
	logic [31:0]          aang, eang;

	logic [63:0]        o_time_q;
	logic [15:0]        o_tgt_q;
	logic signed [31:0] o_p_q [3];
	logic signed [31:0] o_v_q [3];
	logic [31:0]        o_rng_q;
	logic [15:0]        o_az_q, o_el_q;
	logic               out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			target_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_ENABLE) enable_q <= cfg_data[0];
			if (cfg_index == CFG_TARGET) target_q <= cfg_data;
		end
	end

	assign dt = t_q - prev_t_q;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			diff[k] = 33'(p_q[k]) - 33'(prev_q[k]);
		end
		lane = 2'(cmd.idx - 6'd3);
		op_a = '0;
		op_b = '0;
		if (cmd.idx < 6'd3) begin
			op_a = 33'(p_q[cmd.idx[1:0]]);
			op_b = op_a;
		end else if (cmd.idx < MUL_LAST) begin
			op_a = diff[lane];
			op_b = US_PER_S;
		end
		prod_mag = prod_q[65] ? 66'(-prod_q) : 66'(prod_q);
	end

	assign sqrt_bit = 64'h4000_0000_0000_0000 >> {cmd.idx[4:0], 1'b0};
	assign th = rh_q + sqrt_bit;
	assign ts = rs_q + sqrt_bit;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sh[k] = {rem_q[k], quot_q[k][52]};
			ge[k] = sh[k] >= {1'b0, dt_q};
		end
	end

	assign am    = mag_max(ax_q, ay_q);
	assign em    = mag_max(ex_q, ey_q);
	assign adone = azero_q || am >= (44'd1 << 40);
	assign edone = ezero_q || em >= (44'd1 << 40);
	assign ri    = cmd.idx[4:0];

	assign aang = aacc_q + (32'd1 << (ANGLE_SHIFT - 1));
	assign eang = eacc_q + (32'd1 << (ANGLE_SHIFT - 1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			t_q <= in_data[63:0];
			p_q[0] <= in_data[95:64];
			p_q[1] <= in_data[127:96];
			p_q[2] <= in_data[159:128];
		end
		if (cmd.mul) begin
			prod_q <= op_a * op_b;
			if (cmd.idx == 6'd0) begin
				upd_q <= (prev_t_q != 64'd0) && (dt > DT_MIN) && (dt < DT_MAX);
				dt_q  <= dt[19:0];
			end
			if (cmd.idx == 6'd1) sq_q <= prod_q[63:0];
			if (cmd.idx == 6'd2) begin
				sq_q <= sq_q + prod_q[63:0];
				nh_q <= sq_q + prod_q[63:0];
				rh_q <= '0;
			end
			if (cmd.idx == 6'd3) begin
				ns_q <= sq_q + prod_q[63:0];
				rs_q <= '0;
			end
			if (cmd.idx > 6'd3) begin
				dneg_q[2'(cmd.idx - 6'd4)] <= prod_q[65];
				quot_q[2'(cmd.idx - 6'd4)] <= prod_mag[52:0];
				rem_q[2'(cmd.idx - 6'd4)]  <= '0;
			end
		end
		if (cmd.div) begin
			for (int k = 0; k < 3; k++) begin
				rem_q[k]  <= ge[k] ? 20'(sh[k] - {1'b0, dt_q}) : sh[k][19:0];
				quot_q[k] <= {quot_q[k][51:0], ge[k]};
			end
			if (cmd.idx < SQRT_STEPS) begin
				if (nh_q >= th) begin
					nh_q <= nh_q - th;
					rh_q <= (rh_q >> 1) + sqrt_bit;
				end else begin
					rh_q <= rh_q >> 1;
				end
				if (ns_q >= ts) begin
					ns_q <= ns_q - ts;
					rs_q <= (rs_q >> 1) + sqrt_bit;
				end else begin
					rs_q <= rs_q >> 1;
				end
			end
		end
		if (cmd.init) begin
			azero_q <= (p_q[0] == 32'sd0) && (p_q[1] == 32'sd0);
			if (p_q[0] < 0) begin
				ax_q   <= -CW'(p_q[0]);
				ay_q   <= -CW'(p_q[1]);
				aacc_q <= 32'h8000_0000;
			end else begin
				ax_q   <= CW'(p_q[0]);
				ay_q   <= CW'(p_q[1]);
				aacc_q <= '0;
			end
			ezero_q <= (rh_q == 64'd0) && (p_q[2] == 32'sd0);
			ex_q    <= $signed({11'd0, rh_q[32:0]});
			ey_q    <= -CW'(p_q[2]);
			eacc_q  <= '0;
		end
		if (cmd.norm) begin
			if (!adone) begin
				ax_q <= ax_q <<< norm_shift(am);
				ay_q <= ay_q <<< norm_shift(am);
			end
			if (!edone) begin
				ex_q <= ex_q <<< norm_shift(em);
				ey_q <= ey_q <<< norm_shift(em);
			end
		end
		if (cmd.rot) begin
			if (!azero_q) begin
				if (ay_q > 0) begin
					ax_q   <= ax_q + (ay_q >>> ri);
					ay_q   <= ay_q - (ax_q >>> ri);
					aacc_q <= aacc_q + atan_lut(ri);
				end else begin
					ax_q   <= ax_q - (ay_q >>> ri);
					ay_q   <= ay_q + (ax_q >>> ri);
					aacc_q <= aacc_q - atan_lut(ri);
				end
			end
			if (!ezero_q) begin
				if (ey_q > 0) begin
					ex_q   <= ex_q + (ey_q >>> ri);
					ey_q   <= ey_q - (ex_q >>> ri);
					eacc_q <= eacc_q + atan_lut(ri);
				end else begin
					ex_q   <= ex_q - (ey_q >>> ri);
					ey_q   <= ey_q + (ex_q >>> ri);
					eacc_q <= eacc_q - atan_lut(ri);
				end
			end
		end
		if (cmd.emit) begin
			o_time_q <= t_q;
			o_tgt_q  <= target_q;
			o_p_q    <= p_q;
			o_v_q    <= vel_q;
			o_rng_q  <= rs_q[31:0];
			o_az_q   <= 16'(aang >> ANGLE_SHIFT);
			o_el_q   <= 16'(eang >> ANGLE_SHIFT);
		end
	end

	// history and held velocity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_t_q <= '0;
			for (int k = 0; k < 3; k++) begin
				prev_q[k] <= '0;
				vel_q[k]  <= '0;
			end
		end else begin
			if (cmd.init && upd_q) begin
				for (int k = 0; k < 3; k++) begin
					if (dneg_q[k])
						vel_q[k] <= (quot_q[k] > 53'h8000_0000) ? 32'sh8000_0000
							: -$signed(quot_q[k][31:0]);
					else
						vel_q[k] <= (quot_q[k] > 53'h7FFF_FFFF) ? 32'sh7FFF_FFFF
							: $signed(quot_q[k][31:0]);
				end
			end
			if (cmd.emit) begin
				prev_t_q <= t_q;
				prev_q   <= p_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.enabled   = enable_q;
	assign sts.norm_done = adone && edone;
	assign sts.out_busy  = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = {7'd0, 1'b1, o_el_q, o_az_q, o_rng_q,
		o_v_q[2], o_v_q[1], o_v_q[0], o_p_q[2], o_p_q[1], o_p_q[0], o_tgt_q, o_time_q};

endmodule

>>> hw/rtl/position_to_range_bearing_tracker.sv
// Position to range/bearing tracker, top level: stream ports, configuration
// port and the controller/datapath pair. Depends on trk_pkg, trk_ctrl, trk_dp.
//
// When tracking is enabled, each sample transfer goes through these steps in
// order: accept, the products on the shared multiplier, the bit-serial velocity
// dividers (the two square roots run alongside while the step index is below
// SQRT_STEPS), set up of the angle units, normalising shifts until both units
// are seen normalised, the CORDIC rotations, then loading of the report
// register. A sample taken while tracking is disabled is accepted and dropped.
// The report register frees the input side as soon as it is loaded; a stalled
// report holds only the final step of the next sample.

module position_to_range_bearing_tracker import trk_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [15:0]      cfg_data,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// sample_time_us, pos_x, pos_y, pos_z
	input  logic [IN_W-1:0]  s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// report_time_us, report_target, out_x, out_y, out_z, vel_x, vel_y, vel_z,
	// slant_range, azimuth, elevation, report_valid, zero fill
	output logic [OUT_W-1:0] m_axis_tdata
);

	cmd_t cmd;
	sts_t sts;

	trk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	trk_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_axis_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule
